// ----- rtl/core/tecf_pkg.sv -----
package tecf_pkg;

    // action codes carried by each input item
    typedef enum logic [1:0] {
        ACT_EDGE   = 2'd0,
        ACT_PERIOD = 2'd1,
        ACT_POP    = 2'd2,
        ACT_STATUS = 2'd3
    } t_action;

    // sticky flag bit positions
    localparam int FLAG_A_RISE = 0;
    localparam int FLAG_A_FALL = 1;
    localparam int FLAG_B_RISE = 2;
    localparam int FLAG_B_FALL = 3;

    // ring entries, a power of two
    localparam int LOG_DEPTH = 64;
    localparam int FILL_W    = $clog2(LOG_DEPTH) + 1;

    // configuration register indexes (byte address / 4)
    localparam logic REG_PIN_A = 1'b0;
    localparam logic REG_PIN_B = 1'b1;

    localparam logic [7:0] PIN_A_RESET = 8'd0;
    localparam logic [7:0] PIN_B_RESET = 8'd1;

    typedef struct packed {
        t_action     action;
        logic [7:0]  pin;
        logic        level;
        logic [31:0] time_us;
    } t_in_item;

    typedef struct packed {
        logic [31:0]       entry_time;
        logic [31:0]       entry_period;
        logic [7:0]        entry_pin;
        logic              entry_level;
        logic              entry_valid;
        logic              pushed_ok;
        logic [31:0]       drop_total;
        logic [3:0]        seen_flags;
        logic [31:0]       periods_total;
        logic [31:0]       last_period_time;
        logic [FILL_W-1:0] fill_count;
    } t_out_item;

    // one ring entry as held in the memory
    typedef struct packed {
        logic [31:0] time_us;
        logic [31:0] period;
        logic [7:0]  pin;
        logic        level;
    } t_entry;

endpackage

// ----- rtl/core/tecf_ram.sv -----
module tecf_ram
    import tecf_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_entry                   i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_entry                   o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/timestamped_edge_capture_fifo_unit.sv -----
// the result of an item is strobed in the cycle after start is taken
// throughput: one item per cycle while busy is low
// a pop reads the oldest slot at the accept edge and the registered word is the result
// reset (i_rst_n low, synchronous) empties the ring and clears counters, flags and period data;
// busy is high during reset and for the first cycle after; the receiver cannot stall
module timestamped_edge_capture_fifo_unit
    import tecf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_strobe,
    output t_out_item   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(LOG_DEPTH);
    localparam int PW = AW + 1;

    logic          r_busy;
    logic          r_strobe;
    logic [7:0]    r_pin_a;
    logic [7:0]    r_pin_b;
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [31:0]   r_drop;
    logic [3:0]    r_flags;
    logic [31:0]   r_per_cnt;
    logic [31:0]   r_per_time;
    logic          r_pushed;
    logic          r_pop_hit;
    logic [FILL_W-1:0] r_fill;

    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [31:0]   n_drop;
    logic [3:0]    n_flags;
    logic [31:0]   n_per_cnt;
    logic [31:0]   n_per_time;
    logic          n_pushed;
    logic          n_pop_hit;

    logic          accept;
    logic          cfg_wr;
    logic [PW-1:0] fill_now;
    logic          ring_full;
    logic          ring_empty;
    logic          mem_we;
    logic          mem_re;
    t_entry        mem_wdata;
    t_entry        mem_rdata;

    assign accept     = start && !r_busy;
    assign cfg_wr     = psel && penable && pwrite;
    assign fill_now   = r_wr_ptr - r_rd_ptr;
    assign ring_full  = fill_now[AW];
    assign ring_empty = (r_wr_ptr == r_rd_ptr);

    assign mem_wdata.time_us = i_item.time_us;
    assign mem_wdata.period  = r_per_cnt;
    assign mem_wdata.pin     = i_item.pin;
    assign mem_wdata.level   = i_item.level;

    always_comb begin
        n_wr_ptr   = r_wr_ptr;
        n_rd_ptr   = r_rd_ptr;
        n_drop     = r_drop;
        n_flags    = r_flags;
        n_per_cnt  = r_per_cnt;
        n_per_time = r_per_time;
        n_pushed   = 1'b0;
        n_pop_hit  = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        case (i_item.action)
            ACT_EDGE: begin
                if (ring_full) begin
                    n_drop = r_drop + 32'd1;
                end else begin
                    mem_we   = accept;
                    n_wr_ptr = r_wr_ptr + PW'(1);
                    n_pushed = 1'b1;
                    // pin a wins when both registers name the same pin
                    if (i_item.pin == r_pin_a) begin
                        if (i_item.level) begin
                            n_flags[FLAG_A_RISE] = 1'b1;
                        end else begin
                            n_flags[FLAG_A_FALL] = 1'b1;
                        end
                    end else if (i_item.pin == r_pin_b) begin
                        if (i_item.level) begin
                            n_flags[FLAG_B_RISE] = 1'b1;
                        end else begin
                            n_flags[FLAG_B_FALL] = 1'b1;
                        end
                    end
                end
            end
            ACT_PERIOD: begin
                n_per_cnt  = r_per_cnt + 32'd1;
                n_per_time = i_item.time_us;
            end
            ACT_POP: begin
                if (!ring_empty) begin
                    mem_re    = accept;
                    n_rd_ptr  = r_rd_ptr + PW'(1);
                    n_pop_hit = 1'b1;
                end
            end
            ACT_STATUS: begin
            end
            default: begin
            end
        endcase
    end

    tecf_ram #(
        .DEPTH (LOG_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wr_ptr[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_rd_ptr[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_strobe   <= 1'b0;
            r_pin_a    <= PIN_A_RESET;
            r_pin_b    <= PIN_B_RESET;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_drop     <= '0;
            r_flags    <= '0;
            r_per_cnt  <= '0;
            r_per_time <= '0;
        end else begin
            r_busy   <= 1'b0;
            r_strobe <= accept;
            if (accept) begin
                r_wr_ptr   <= n_wr_ptr;
                r_rd_ptr   <= n_rd_ptr;
                r_drop     <= n_drop;
                r_flags    <= n_flags;
                r_per_cnt  <= n_per_cnt;
                r_per_time <= n_per_time;
            end
            if (cfg_wr) begin
                case (paddr[2])
                    REG_PIN_A: r_pin_a <= pwdata[7:0];
                    REG_PIN_B: r_pin_b <= pwdata[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // result flags, held for the strobe cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pushed  <= n_pushed;
            r_pop_hit <= n_pop_hit;
            r_fill    <= FILL_W'(n_wr_ptr - n_rd_ptr);
        end
    end

    always_comb begin
        o_result                  = '0;
        o_result.entry_time       = r_pop_hit ? mem_rdata.time_us : 32'd0;
        o_result.entry_period     = r_pop_hit ? mem_rdata.period  : 32'd0;
        o_result.entry_pin        = r_pop_hit ? mem_rdata.pin     : 8'd0;
        o_result.entry_level      = r_pop_hit && mem_rdata.level;
        o_result.entry_valid      = r_pop_hit;
        o_result.pushed_ok        = r_pushed;
        o_result.drop_total       = r_drop;
        o_result.seen_flags       = r_flags;
        o_result.periods_total    = r_per_cnt;
        o_result.last_period_time = r_per_time;
        o_result.fill_count       = r_fill;
    end

    assign o_strobe = r_strobe;
    assign busy     = r_busy;
    assign pready   = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_PIN_A: prdata = {24'd0, r_pin_a};
            REG_PIN_B: prdata = {24'd0, r_pin_b};
            default:   prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/core/tecf_checker.sv -----
module tecf_checker
    import tecf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input t_in_item    i_item,
    input logic        o_strobe,
    input t_out_item   o_result,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // each transfer in gives exactly one result on the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (o_strobe == $past(start && !busy)))
        else $error("result strobe does not follow accepted item");

    // an item is either stored or popped, never both
    a_push_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_result.pushed_ok && o_result.entry_valid))
        else $error("push and pop reported together");

    // no returned entry means the entry fields read as zero
    a_empty_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.entry_valid) |->
            (o_result.entry_time == 32'd0 && o_result.entry_period == 32'd0 &&
             o_result.entry_pin == 8'd0 && !o_result.entry_level))
        else $error("entry fields not zero without a popped entry");

    // after the cycle in which reset is released, the block always takes items
    a_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy raised outside reset");

endmodule

bind timestamped_edge_capture_fifo_unit tecf_checker u_tecf_checker (.*);
